// ===== hw/rtl/uer_pkg.sv =====
`timescale 1ns / 1ps

package uer_pkg;

	localparam int unsigned CPU_W   = 8;
	localparam int unsigned WAIT_W  = 20;
	localparam int unsigned CAP_W   = 16;
	localparam int unsigned DIST_W  = 13;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned WDATA_W = 20;

	localparam logic [IDX_W-1:0] REG_CLOCKS_PER_US   = 2'd0;
	localparam logic [IDX_W-1:0] REG_ECHO_WAIT_LIMIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_ECHO_COUNT_CAP  = 2'd2;
	localparam logic [IDX_W-1:0] REG_NEAR_LIMIT      = 2'd3;

	localparam logic [CPU_W-1:0]  CLOCKS_PER_US_RST   = 8'd120;
	localparam logic [WAIT_W-1:0] ECHO_WAIT_LIMIT_RST = 20'd100000;
	localparam logic [CAP_W-1:0]  ECHO_COUNT_CAP_RST  = 16'd40000;
	localparam logic [DIST_W-1:0] NEAR_LIMIT_RST      = 13'd30;

	localparam logic [WAIT_W-1:0] TRIG_LOW_TICKS  = 20'd2;
	localparam logic [WAIT_W-1:0] TRIG_HIGH_TICKS = 20'd10;
	localparam logic [WAIT_W-1:0] WAIT_SAT        = 20'hFFFFF;
	localparam logic [DIST_W-1:0] FAR_CODE        = 13'd999;

	typedef struct packed {
		logic [CPU_W-1:0]  clocks_per_us;
		logic [WAIT_W-1:0] echo_wait_limit;
		logic [CAP_W-1:0]  echo_count_cap;
		logic [DIST_W-1:0] near_limit;
	} cfg_t;

	typedef struct packed {
		logic              no_echo;
		logic              near;
		logic [DIST_W-1:0] distance;
		logic              done_res;
		logic              busy_res;
		logic              trigger;
	} res_t;

	// Divide by ten as a multiply by the scaled reciprocal; exact for all 16-bit inputs.
	function automatic logic [DIST_W-1:0] div10(input logic [CAP_W-1:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'd52429;
		return p[31:19];
	endfunction

endpackage

// ===== hw/rtl/uer_cfg.sv =====
`timescale 1ns / 1ps

module uer_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [uer_pkg::IDX_W-1:0]   wr_index,
	input  logic [uer_pkg::WDATA_W-1:0] wr_data,
	output uer_pkg::cfg_t               cfg
);

	uer_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clocks_per_us   <= uer_pkg::CLOCKS_PER_US_RST;
			cfg_q.echo_wait_limit <= uer_pkg::ECHO_WAIT_LIMIT_RST;
			cfg_q.echo_count_cap  <= uer_pkg::ECHO_COUNT_CAP_RST;
			cfg_q.near_limit      <= uer_pkg::NEAR_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				uer_pkg::REG_CLOCKS_PER_US: begin
					cfg_q.clocks_per_us <= wr_data[uer_pkg::CPU_W-1:0];
				end
				uer_pkg::REG_ECHO_WAIT_LIMIT: begin
					cfg_q.echo_wait_limit <= wr_data[uer_pkg::WAIT_W-1:0];
				end
				uer_pkg::REG_ECHO_COUNT_CAP: begin
					cfg_q.echo_count_cap <= wr_data[uer_pkg::CAP_W-1:0];
				end
				uer_pkg::REG_NEAR_LIMIT: begin
					cfg_q.near_limit <= wr_data[uer_pkg::DIST_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/uer_ctrl.sv =====
`timescale 1ns / 1ps

module uer_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          start_req,
	input  logic          echo,
	input  uer_pkg::cfg_t cfg,
	output uer_pkg::res_t res
);

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TRIG_LOW  = 3'd1,
		PH_TRIG_HIGH = 3'd2,
		PH_WAIT      = 3'd3,
		PH_MEASURE   = 3'd4
	} phase_t;

	phase_t                        phase_q, phase_d;
	logic [uer_pkg::CPU_W-1:0]     prescale_q, prescale_d;
	logic [uer_pkg::WAIT_W-1:0]    phase_ticks_q, phase_ticks_d;
	logic [uer_pkg::CAP_W-1:0]     echo_ticks_q, echo_ticks_d;
	logic [uer_pkg::DIST_W-1:0]    last_dist_q, last_dist_d;
	logic                          last_near_q, last_near_d;
	logic                          last_no_echo_q, last_no_echo_d;
	logic [uer_pkg::CPU_W-1:0]     div;
	logic [uer_pkg::CPU_W:0]       pre_inc;
	logic [uer_pkg::WAIT_W-1:0]    ticks_inc;
	logic [uer_pkg::DIST_W-1:0]    latch_dist;
	logic                          tick;
	logic                          done;
	logic                          do_latch;

	always_comb begin
		div        = (cfg.clocks_per_us == '0) ? uer_pkg::CPU_W'(1) : cfg.clocks_per_us;
		pre_inc    = {1'b0, prescale_q} + 9'd1;
		tick       = 1'b0;
		done       = 1'b0;
		do_latch   = 1'b0;
		latch_dist = '0;
		prescale_d     = prescale_q;
		phase_d        = phase_q;
		phase_ticks_d  = phase_ticks_q;
		echo_ticks_d   = echo_ticks_q;
		last_dist_d    = last_dist_q;
		last_near_d    = last_near_q;
		last_no_echo_d = last_no_echo_q;
		ticks_inc      = phase_ticks_q + 20'd1;

		if (phase_q != PH_IDLE) begin
			if (pre_inc >= {1'b0, div}) begin
				tick       = 1'b1;
				prescale_d = '0;
			end else begin
				prescale_d = pre_inc[uer_pkg::CPU_W-1:0];
			end
		end

		case (phase_q)
			PH_TRIG_LOW: begin
				if (tick) begin
					phase_ticks_d = ticks_inc;
					if (ticks_inc >= uer_pkg::TRIG_LOW_TICKS) begin
						phase_d       = PH_TRIG_HIGH;
						phase_ticks_d = '0;
					end
				end
			end
			PH_TRIG_HIGH: begin
				if (tick) begin
					phase_ticks_d = ticks_inc;
					if (ticks_inc >= uer_pkg::TRIG_HIGH_TICKS) begin
						phase_d       = PH_WAIT;
						phase_ticks_d = '0;
					end
				end
			end
			PH_WAIT: begin
				if (echo) begin
					phase_d      = PH_MEASURE;
					echo_ticks_d = '0;
					prescale_d   = '0;
				end else if (tick) begin
					if (phase_ticks_q != uer_pkg::WAIT_SAT) begin
						phase_ticks_d = ticks_inc;
					end
					if (phase_ticks_d >= cfg.echo_wait_limit) begin
						do_latch       = 1'b1;
						latch_dist     = uer_pkg::FAR_CODE;
						last_no_echo_d = 1'b1;
					end
				end
			end
			PH_MEASURE: begin
				if (!echo || echo_ticks_q >= cfg.echo_count_cap) begin
					do_latch       = 1'b1;
					latch_dist     = uer_pkg::div10(echo_ticks_q);
					last_no_echo_d = 1'b0;
				end else if (tick) begin
					echo_ticks_d = echo_ticks_q + 16'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (start_req) begin
					phase_d       = PH_TRIG_LOW;
					phase_ticks_d = '0;
					prescale_d    = '0;
					echo_ticks_d  = '0;
				end
			end
		endcase

		if (do_latch) begin
			done          = 1'b1;
			last_dist_d   = latch_dist;
			last_near_d   = (latch_dist != '0) && (latch_dist <= cfg.near_limit);
			phase_d       = PH_IDLE;
			phase_ticks_d = '0;
			prescale_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			prescale_q     <= '0;
			phase_ticks_q  <= '0;
			echo_ticks_q   <= '0;
			last_dist_q    <= '0;
			last_near_q    <= 1'b0;
			last_no_echo_q <= 1'b0;
		end else if (adv) begin
			phase_q        <= phase_d;
			prescale_q     <= prescale_d;
			phase_ticks_q  <= phase_ticks_d;
			echo_ticks_q   <= echo_ticks_d;
			last_dist_q    <= last_dist_d;
			last_near_q    <= last_near_d;
			last_no_echo_q <= last_no_echo_d;
		end
	end

	always_comb begin
		res.trigger  = (phase_d == PH_TRIG_HIGH);
		res.busy_res = (phase_d != PH_IDLE);
		res.done_res = done;
		res.distance = last_dist_d;
		res.near     = last_near_d;
		res.no_echo  = last_no_echo_d;
	end

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps

// Ultrasonic trigger/echo ranging controller. Each input transfer is one sample of the start
// request and the echo pin, and it yields exactly one output transfer with the trigger level,
// status and latest result as they stand after that sample; the controller advances only on
// input transfers. It takes one transfer per clock cycle, and the result of a sample sits in
// the output register from the next cycle on. The sustained rate is set by that output
// register alone: a new sample is taken whenever the register is empty or is drained in the
// same cycle. Microsecond ticks come from a prescaler of clocks_per_us samples, a start drives
// the trigger low for 2 ticks and high for 10, and the distance is the echo-high tick count
// (capped at echo_count_cap) divided by ten, or 999 with no_echo set when the echo does not rise in time.
module ultrasonic_echo_ranger (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // start_req, echo
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,  // trigger, busy_res, done_res, distance, near, no_echo
	input  logic                        wr_en,
	input  logic [uer_pkg::IDX_W-1:0]   wr_index,
	input  logic [uer_pkg::WDATA_W-1:0] wr_data
);

	uer_pkg::cfg_t cfg;
	uer_pkg::res_t res;
	uer_pkg::res_t res_q;
	logic          out_valid_q;
	logic          accept;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	uer_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	uer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (accept),
		.start_req (s_tdata[0]),
		.echo      (s_tdata[1]),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};

endmodule

// ===== tb/sv/ultrasonic_echo_ranger_tb.sv =====
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb;

	import uer_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef enum logic [2:0] {
		RNG_IDLE,
		RNG_TRIG_LOW,
		RNG_TRIG_HIGH,
		RNG_WAIT,
		RNG_MEASURE
	} ranger_phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [23:0]         m_tdata;
	logic                wr_en = 1'b0;
	logic [IDX_W-1:0]    wr_index = '0;
	logic [WDATA_W-1:0]  wr_data = '0;

	logic [7:0]          sample_q[$];
	res_t                reading_q[$];
	int unsigned         err_cnt = 0;
	int unsigned         cyc = 0;
	int unsigned         n_items = 0;
	bit                  steady = 1'b0;

	cfg_t                cfg_model;
	logic [CPU_W-1:0]    pre_cnt;
	ranger_phase_t       rng_ph;
	logic [WAIT_W-1:0]   ph_ticks;
	logic [CAP_W-1:0]    echo_cnt;
	logic [DIST_W-1:0]   held_dist;
	logic                held_near;
	logic                held_no_echo;

	ultrasonic_echo_ranger u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void hold_result(input logic [DIST_W-1:0] dist_val, input logic timed_out);
		held_dist = dist_val;
		held_near = (dist_val != '0) && (dist_val <= cfg_model.near_limit);
		held_no_echo = timed_out;
		rng_ph = RNG_IDLE;
		ph_ticks = '0;
		pre_cnt = '0;
	endfunction

	// Advances the ranging state by one sample and returns the status that follows it.
	function automatic res_t ranger_step(input logic start, input logic echo);
		logic [8:0] div_n;
		logic       tick;
		logic       done;
		res_t       r;
		div_n = (cfg_model.clocks_per_us == '0) ? 9'd1 : {1'b0, cfg_model.clocks_per_us};
		tick = 1'b0;
		done = 1'b0;
		if (rng_ph != RNG_IDLE) begin
			if ({1'b0, pre_cnt} + 9'd1 >= div_n) begin
				tick = 1'b1;
				pre_cnt = '0;
			end else begin
				pre_cnt = pre_cnt + 1'b1;
			end
		end
		case (rng_ph)
			RNG_TRIG_LOW: begin
				if (tick) begin
					ph_ticks = ph_ticks + 1'b1;
					if (ph_ticks >= TRIG_LOW_TICKS) begin
						rng_ph = RNG_TRIG_HIGH;
						ph_ticks = '0;
					end
				end
			end
			RNG_TRIG_HIGH: begin
				if (tick) begin
					ph_ticks = ph_ticks + 1'b1;
					if (ph_ticks >= TRIG_HIGH_TICKS) begin
						rng_ph = RNG_WAIT;
						ph_ticks = '0;
					end
				end
			end
			RNG_WAIT: begin
				if (echo) begin
					rng_ph = RNG_MEASURE;
					echo_cnt = '0;
					pre_cnt = '0;
				end else if (tick) begin
					if (ph_ticks < WAIT_SAT)
						ph_ticks = ph_ticks + 1'b1;
					if (ph_ticks >= cfg_model.echo_wait_limit) begin
						hold_result(FAR_CODE, 1'b1);
						done = 1'b1;
					end
				end
			end
			RNG_MEASURE: begin
				if (!echo || echo_cnt >= cfg_model.echo_count_cap) begin
					hold_result(DIST_W'(echo_cnt / 16'd10), 1'b0);
					done = 1'b1;
				end else if (tick) begin
					echo_cnt = echo_cnt + 1'b1;
				end
			end
			default: begin
				rng_ph = RNG_IDLE;
				if (start) begin
					rng_ph = RNG_TRIG_LOW;
					ph_ticks = '0;
					pre_cnt = '0;
					echo_cnt = '0;
				end
			end
		endcase
		r.trigger = (rng_ph == RNG_TRIG_HIGH);
		r.busy_res = (rng_ph != RNG_IDLE);
		r.done_res = done;
		r.distance = held_dist;
		r.near = held_near;
		r.no_echo = held_no_echo;
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				reading_q.push_back(ranger_step(s_tdata[0], s_tdata[1]));
			if (!s_tvalid || s_tready) begin
				if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
					s_tvalid <= 1'b1;
					s_tdata <= sample_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[17:0];
				if (reading_q.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
					err_cnt++;
				end else begin
					want = reading_q.pop_front();
					check_field("trigger", want.trigger, got.trigger);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("distance", want.distance, got.distance);
					check_field("near", want.near, got.near);
					check_field("no_echo", want.no_echo, got.no_echo);
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("** ultrasonic_echo_ranger: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WDATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CLOCKS_PER_US:   cfg_model.clocks_per_us = val[CPU_W-1:0];
			REG_ECHO_WAIT_LIMIT: cfg_model.echo_wait_limit = val[WAIT_W-1:0];
			REG_ECHO_COUNT_CAP:  cfg_model.echo_count_cap = val[CAP_W-1:0];
			default:             cfg_model.near_limit = val[DIST_W-1:0];
		endcase
	endtask

	task automatic load_regs(input int unsigned cpu, input int unsigned wlim,
			input int unsigned cap, input int unsigned nl);
		write_reg(REG_CLOCKS_PER_US, WDATA_W'(cpu));
		write_reg(REG_ECHO_WAIT_LIMIT, WDATA_W'(wlim));
		write_reg(REG_ECHO_COUNT_CAP, WDATA_W'(cap));
		write_reg(REG_NEAR_LIMIT, WDATA_W'(nl));
	endtask

	task automatic settle();
		while (sample_q.size() != 0 || s_tvalid || reading_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_sample(input logic start, input logic echo);
		sample_q.push_back({6'd0, echo, start});
		n_items++;
	endtask

	function automatic logic coin();
		return logic'($urandom_range(1));
	endfunction

	// One ranging cycle: start, trigger span with optional noise, a quiet wait, an echo pulse
	// and a low tail whose first sample may carry a start that lands in the done cycle.
	task automatic queue_ranging(input int unsigned wait_n, input int unsigned high_n,
			input bit noisy, input bit done_start);
		int unsigned div_n;
		div_n = (cfg_model.clocks_per_us == '0) ? 1 : cfg_model.clocks_per_us;
		repeat ($urandom_range(0, 2)) queue_sample(1'b0, noisy && coin());
		queue_sample(1'b1, noisy && coin());
		repeat ((TRIG_LOW_TICKS + TRIG_HIGH_TICKS) * div_n)
			queue_sample(noisy && coin(), noisy && coin());
		repeat (wait_n) queue_sample(1'b0, 1'b0);
		repeat (high_n) queue_sample(1'b0, 1'b1);
		queue_sample(done_start, 1'b0);
		repeat ($urandom_range(1, 2)) queue_sample(1'b0, 1'b0);
	endtask

	initial begin
		int unsigned div_n;
		int unsigned tmo;
		int unsigned wait_n;
		int unsigned high_n;
		int unsigned cpu;
		int unsigned cap;
		int unsigned nl;
		int unsigned pick;
		int unsigned rand_start;
		bit          ds;

		cfg_model.clocks_per_us = CLOCKS_PER_US_RST;
		cfg_model.echo_wait_limit = ECHO_WAIT_LIMIT_RST;
		cfg_model.echo_count_cap = ECHO_COUNT_CAP_RST;
		cfg_model.near_limit = NEAR_LIMIT_RST;
		pre_cnt = '0;
		rng_ph = RNG_IDLE;
		ph_ticks = '0;
		echo_cnt = '0;
		held_dist = '0;
		held_near = 1'b0;
		held_no_echo = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: idle echo is ignored, a start begins, a start while busy is ignored.
		queue_sample(1'b0, 1'b0);
		queue_sample(1'b0, 1'b1);
		queue_sample(1'b1, 1'b1);
		queue_sample(1'b1, 1'b0);
		queue_sample(1'b0, 1'b1);
		queue_sample(1'b1, 1'b1);
		settle();

		// A zero prescale makes every sample a tick; zero wait and zero cap end at once.
		load_regs(0, 0, 0, 0);
		repeat (16) queue_sample(1'b0, 1'b0);
		queue_ranging(2, 0, 1'b1, 1'b0);
		queue_ranging(0, 3, 1'b1, 1'b0);
		settle();

		// A long prescale with a one-tick timeout; the far code reads as near here.
		load_regs(12, 1, 65535, 8191);
		queue_ranging(30, 1, 1'b1, 1'b0);
		settle();

		load_regs(1, 20'hFFFFF, 3, 1);
		queue_ranging(7, 10, 1'b0, 1'b0);
		settle();

		load_regs(2, 5, 65535, 999);
		queue_ranging(3, 45, 1'b1, 1'b1);
		settle();

		rand_start = n_items;
		for (int p = 0; n_items - rand_start < 300; p++) begin
			pick = $urandom_range(99);
			if (pick < 70)
				cpu = $urandom_range(1, 2);
			else if (pick < 85)
				cpu = $urandom_range(3, 4);
			else if (pick < 95)
				cpu = 0;
			else
				cpu = $urandom_range(5, 8);
			pick = $urandom_range(99);
			if (pick < 80)
				cap = $urandom_range(1, 80);
			else if (pick < 90)
				cap = 0;
			else
				cap = $urandom_range(81, 300);
			pick = $urandom_range(99);
			if (pick < 50)
				nl = $urandom_range(0, 8);
			else if (pick < 80)
				nl = $urandom_range(0, 8191);
			else
				nl = $urandom_range(900, 1100);
			load_regs(cpu, $urandom_range(0, 25), cap, nl);
			steady = (p <= 1);
			div_n = (cpu == 0) ? 1 : cpu;
			tmo = cfg_model.echo_wait_limit * div_n;
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(99) < 15) begin
					repeat ($urandom_range(5, 20)) queue_sample(coin(), coin());
				end else begin
					wait_n = $urandom_range(0, tmo + 3);
					high_n = $urandom_range(1, 60);
					ds = coin() && (wait_n + 2 < tmo) && (high_n / div_n + 1 < cap);
					queue_ranging(wait_n, high_n, coin(), ds);
				end
			end
			settle();
		end
		steady = 1'b0;

		settle();
		if (err_cnt == 0)
			$display("** ultrasonic_echo_ranger: PASSED **");
		else
			$display("** ultrasonic_echo_ranger: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/uer_pkg.sv
hw/rtl/uer_cfg.sv
hw/rtl/uer_ctrl.sv
hw/rtl/ultrasonic_echo_ranger.sv
tb/sv/ultrasonic_echo_ranger_tb.sv
